[hw/rtl/assert_macros.svh]
// Assertion macros for the histogram RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define FBH_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define FBH_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fbh_pkg.sv]
// Package for the fixed-bin histogram: operation and register codes,
// field widths, reset values and the structs passed between modules.
// No dependencies.
`default_nettype none

package fbh_pkg;

	localparam int MAX_BINS_DEF = 256;

	// Field widths
	localparam int SAMPLE_W = 32;
	localparam int VAL_W    = 31;
	localparam int SIZE_W   = 16;
	localparam int COUNT_W  = 9;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 63;

	// Operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register select (byte address bit 2)
	localparam logic REG_BIN_SIZE  = 1'b0;
	localparam logic REG_BIN_COUNT = 1'b1;

	// Reset values
	localparam logic [SIZE_W-1:0]  RESET_BIN_SIZE  = 16'd1;
	localparam logic [COUNT_W-1:0] RESET_BIN_COUNT = 9'd256;
	localparam logic [VAL_W-1:0]   RESET_MIN       = 31'(RESET_BIN_SIZE * RESET_BIN_COUNT);

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_en;
	} fbh_mem_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fbh_div_st_t;

endpackage

`default_nettype wire

[hw/rtl/fixed_bin_histogram_with_stats_unit.sv]
// Top level of the fixed-bin histogram with running statistics.
// Depends on fbh_pkg, fbh_div, fbh_bin_mem and assert_macros.svh.
//
// Usage
//  - Input stream (s_*): one transaction per item. s_tuser carries the
//    operation (add, clear, read); s_tdata carries the sample and the bin
//    index to read. s_tready is high only while no item is in flight.
//  - Output stream (m_*): exactly one transaction per input item, carrying
//    the accepted flag, the bin value read and the statistics after the item.
//  - Path to m_tvalid: an add with a non-negative sample passes the
//    bit-serial divider (31 quotient bits, one per cycle), then the read,
//    update and done states; other items skip the divider. No new item is
//    taken until the last leaves the done state; the divider sets the add rate.
//  - The result sits in an output register: the next item is taken while it
//    waits. If the receiver stalls, the finished second item holds in its
//    last stage and s_tready stays low until the output register frees.
//  - Reset clears the histogram, statistics and control registers at once (valid bits
//    on the bin store); no clearing pass is needed.
//  - APB port: bin_size at 0x0, bin_count at 0x4; write only while idle.
`default_nettype none
`include "assert_macros.svh"

module fixed_bin_histogram_with_stats_unit #(
	parameter int MAX_BINS = fbh_pkg::MAX_BINS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // sample[31:0], read_index[40:32], zeros
	input  wire logic [1:0]   s_tuser,   // operation[1:0]
	// Output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [191:0] m_tdata,   // accepted[0], bin_value[32:1],
	                                     // sample_total[64:33], sample_sum[127:65],
	                                     // min_seen[158:128], max_seen[189:159], zeros
	// Configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);
	import fbh_pkg::*;

	localparam int IW = $clog2(MAX_BINS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// Configuration registers
	logic [SIZE_W-1:0]  bin_size_q;
	logic [COUNT_W-1:0] bin_count_q;

	// Item in flight
	logic [2:0]          state_q;
	logic [1:0]          op_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [COUNT_W-1:0]  idx_q;
	logic [IW-1:0]       addr_q;
	logic                res_acc_q;
	logic [CNT_W-1:0]    res_val_q;

	// Statistics
	logic [CNT_W-1:0] total_q;
	logic [SUM_W-1:0] sum_q;
	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] max_q;

	// Output register
	logic         m_tvalid_q;
	logic [191:0] m_tdata_q;

	logic                 cfg_wr;
	logic [IW-1:0]        bins_used;
	logic                 s_fire;
	logic                 start_div;
	logic                 out_free;
	logic                 add_ok;
	logic                 idx_ok;
	logic [VAL_W-1:0]     val;
	logic [SUM_W:0]       sum_next;
	logic [24:0]          clr_min;
	logic [CNT_W-1:0]     bin_rd;
	logic [CNT_W-1:0]     bin_inc;
	logic [IW-1:0]        quot_bin;
	logic [VAL_W-1:0]     quot;
	fbh_div_st_t          div_st;
	fbh_mem_ctl_t         mem_ctl;

	// ---------------------------------------------------------------
	// Configuration port: bit 2 of the byte address picks the register
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_BIN_COUNT) ? {23'd0, bin_count_q} : {16'd0, bin_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q  <= RESET_BIN_SIZE;
			bin_count_q <= RESET_BIN_COUNT;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BIN_SIZE) begin
				bin_size_q <= pwdata[SIZE_W-1:0];
			end else begin
				bin_count_q <= pwdata[COUNT_W-1:0];
			end
		end
	end

	// Bins in use: bin_count limited to the store size; overflow bin sits here
	assign bins_used = ({23'd0, bin_count_q} > 32'(MAX_BINS)) ? IW'(MAX_BINS)
	                                                           : IW'(bin_count_q);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign start_div = s_fire && (s_tuser == OP_ADD) && !s_tdata[SAMPLE_W-1];
	assign out_free  = !m_tvalid_q || m_tready;

	fbh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_div),
		.dividend (s_tdata[VAL_W-1:0]),
		.divisor  (bin_size_q),
		.status   (div_st),
		.quotient (quot)
	);

	// Clamp the quotient to the overflow bin; a zero divisor yields all ones
	assign quot_bin = ({1'b0, quot} > 32'(bins_used)) ? bins_used : IW'(quot);

	assign mem_ctl.rd_en  = (state_q == ST_RD);
	assign mem_ctl.wr_en  = (state_q == ST_UPD) && add_ok;
	assign mem_ctl.clr_en = (state_q == ST_UPD) && (op_q == OP_CLEAR);

	fbh_bin_mem #(
		.MAX_BINS (MAX_BINS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.rd_addr  (addr_q),
		.wr_addr  (addr_q),
		.wr_data  (bin_inc),
		.clr_last (bins_used),
		.rd_data  (bin_rd)
	);

	// Update terms, used in the update state
	assign add_ok   = (op_q == OP_ADD) && !sample_q[SAMPLE_W-1];
	assign idx_ok   = ({23'd0, idx_q} <= 32'(bins_used));
	assign val      = sample_q[VAL_W-1:0];
	assign bin_inc  = (bin_rd == '1) ? bin_rd : bin_rd + 1'b1;
	assign sum_next = {1'b0, sum_q} + {33'd0, val};
	assign clr_min  = {9'd0, bin_size_q} * {16'd0, bin_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			sum_q      <= '0;
			min_q      <= RESET_MIN;
			max_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Load a finished result, else drop the one just taken
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= start_div ? ST_DIV : ST_RD;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (add_ok) begin
						if (val < min_q) begin
							min_q <= val;
						end
						if (val > max_q) begin
							max_q <= val;
						end
						sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
						if (total_q != '1) begin
							total_q <= total_q + 1'b1;
						end
					end else if (op_q == OP_CLEAR) begin
						total_q <= '0;
						sum_q   <= '0;
						min_q   <= {6'd0, clr_min};
						max_q   <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold here while the receiver stalls the previous result
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q     <= s_tuser;
			sample_q <= s_tdata[SAMPLE_W-1:0];
			idx_q    <= s_tdata[40:32];
			addr_q   <= IW'(s_tdata[40:32]);
		end else if ((state_q == ST_DIV) && div_st.done) begin
			addr_q <= quot_bin;
		end
		if (state_q == ST_UPD) begin
			res_acc_q <= add_ok;
			res_val_q <= ((op_q == OP_READ) && idx_ok) ? bin_rd : '0;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {2'd0, max_q, min_q, sum_q, total_q, res_val_q, res_acc_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`FBH_ASSERT_SAME(a_div_in_div_state, div_st.busy, state_q == ST_DIV,
		"divider busy outside the divide state")
	`FBH_ASSERT_SAME(a_result_from_done, $rose(m_tvalid_q), $past(state_q == ST_DONE),
		"result raised without a finished item")
	`FBH_ASSERT_NEXT(a_total_monotonic, (state_q == ST_UPD) && (op_q != OP_CLEAR),
		total_q >= $past(total_q), "sample total decreased without a clear")
	`FBH_ASSERT_SAME(a_accept_only_add, (state_q == ST_DONE) && res_acc_q,
		op_q == OP_ADD, "accepted flag set for a non-add item")

endmodule

`default_nettype wire

[hw/rtl/fbh_div.sv]
// Bit-serial restoring divider: 31-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Depends on fbh_pkg.
`default_nettype none

module fbh_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [fbh_pkg::VAL_W-1:0]  dividend,
	input  wire logic [fbh_pkg::SIZE_W-1:0] divisor,
	output fbh_pkg::fbh_div_st_t            status,
	output logic      [fbh_pkg::VAL_W-1:0]  quotient
);
	import fbh_pkg::*;

	localparam int CW = $clog2(VAL_W);
	localparam logic [CW-1:0] LAST_STEP = CW'(VAL_W - 1);

	logic [VAL_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [SIZE_W:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SIZE_W:0]   rem_sh;
	logic [SIZE_W+1:0] diff;
	logic              qbit;

	// Shift in the next dividend bit, trial-subtract, keep on no borrow
	assign rem_sh = {rem_q[SIZE_W-1:0], dvd_q[VAL_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign qbit   = !diff[SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VAL_W-2:0], qbit};
			rem_q <= qbit ? diff[SIZE_W:0] : rem_sh;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

`default_nettype wire

[hw/rtl/fbh_bin_mem.sv]
// Bin count store: MAX_BINS+1 words of 32 bits with one valid bit per
// entry so that reset and clear take effect at once. Depends on fbh_pkg.
`default_nettype none

module fbh_bin_mem #(
	parameter int MAX_BINS = fbh_pkg::MAX_BINS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fbh_pkg::fbh_mem_ctl_t              ctl,
	input  wire logic [$clog2(MAX_BINS+1)-1:0]      rd_addr,
	input  wire logic [$clog2(MAX_BINS+1)-1:0]      wr_addr,
	input  wire logic [fbh_pkg::CNT_W-1:0]          wr_data,
	input  wire logic [$clog2(MAX_BINS+1)-1:0]      clr_last,
	output logic      [fbh_pkg::CNT_W-1:0]          rd_data
);
	import fbh_pkg::*;

	localparam int DEPTH = MAX_BINS + 1;

	logic [CNT_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rd_word_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// Clear drops the valid bits of entries 0..clr_last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.clr_en) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (i <= int'(clr_last)) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire
